// ===== rtl/lagf_pkg.sv =====
// Shared constants, payload structs and internal token types of the 3x3 grow filter.
// Used by every module in rtl/; depends on nothing.
package lagf_pkg;

  localparam int MaxWidth   = 62;
  localparam int ColW       = $clog2(MaxWidth);
  localparam int WidthW     = 6;
  localparam int HeightW    = 12;
  localparam int RowW       = HeightW + 1;
  localparam int CfgIndexW  = 2;
  localparam int CfgDataW   = 12;
  localparam int SumW       = 12;
  localparam int QueueDepth = 4;
  localparam int QueueAddrW = $clog2(QueueDepth);

  localparam logic [7:0]         ChanMax     = 8'd255;
  localparam logic [WidthW-1:0]  WidthReset  = 6'd16;
  localparam logic [HeightW-1:0] HeightReset = 12'd16;

  typedef enum logic [CfgIndexW-1:0] {
    REG_FRAME_WIDTH  = 2'd0,
    REG_FRAME_HEIGHT = 2'd1
  } cfg_reg_t;

  typedef struct packed {
    logic [7:0] src_luma;
    logic [7:0] src_alpha;
    logic [7:0] prior_luma;
    logic [7:0] prior_alpha;
  } pix_t;

  typedef struct packed {
    logic [7:0] out_luma;
    logic [7:0] out_alpha;
    logic       frame_end;
  } res_t;

  typedef struct packed {
    logic [7:0] luma;
    logic [7:0] alpha;
  } pel_t;

  // One window column: three source rows plus the prior pixel of the middle row.
  typedef struct packed {
    pel_t top;
    pel_t mid;
    pel_t bot;
    pel_t prior;
  } column_t;

  // Line store entry for one column: the two previous source rows and the
  // prior pixel of the row just above.
  typedef struct packed {
    pel_t up1;
    pel_t up2;
    pel_t prior1;
  } line_t;

  typedef struct packed {
    logic emit;
    logic frame_end;
    logic left_mask;
    logic right_mask;
    logic top_mask;
    logic bot_mask;
  } tok_ctl_t;

  typedef struct packed {
    pel_t            src;
    pel_t            prior;
    logic [ColW-1:0] col;
    tok_ctl_t        ctl;
  } token_t;

endpackage

// ===== rtl/lagf_front.sv =====
// Front end: configuration registers, raster position counters and end-of-frame flush.
// Classifies each item into a token for the back end; uses lagf_pkg.
module lagf_front (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            pix_valid,
  output logic                            pix_ready,
  input  lagf_pkg::pix_t                  pix,
  input  logic                            cfg_wen,
  input  logic [lagf_pkg::CfgIndexW-1:0]  cfg_index,
  input  logic [lagf_pkg::CfgDataW-1:0]   cfg_data,
  input  logic                            q_full,
  output logic                            push,
  output lagf_pkg::token_t                tok
);

  localparam int WidthW  = lagf_pkg::WidthW;
  localparam int HeightW = lagf_pkg::HeightW;
  localparam int RowW    = lagf_pkg::RowW;
  localparam int ColW    = lagf_pkg::ColW;

  logic [WidthW-1:0]  ew;
  logic [HeightW-1:0] eh;
  logic [ColW-1:0]    col;
  logic [RowW-1:0]    row;
  logic               flushing;

  logic [WidthW-1:0]  w_clamp;
  logic [HeightW-1:0] h_clamp;
  logic               col_last;
  logic               row_last;
  logic               final_tok;
  logic               wrap;
  logic [RowW-1:0]    centre_row;

  always_comb begin
    priority if (cfg_data[WidthW-1:0] == '0) begin
      w_clamp = WidthW'(1);
    end else if (cfg_data[WidthW-1:0] > WidthW'(lagf_pkg::MaxWidth)) begin
      w_clamp = WidthW'(lagf_pkg::MaxWidth);
    end else begin
      w_clamp = cfg_data[WidthW-1:0];
    end
    h_clamp = cfg_data[HeightW-1:0];
    if (h_clamp == '0) begin
      h_clamp = HeightW'(1);
    end
  end

  assign pix_ready = !flushing && !q_full;
  assign push      = (pix_valid && pix_ready) || (flushing && !q_full);

  assign col_last  = WidthW'(col) == ew - WidthW'(1);
  assign row_last  = row == RowW'(eh) - RowW'(1);
  assign final_tok = flushing && (row == RowW'(eh) + RowW'(1));

  // A token in column zero closes the right-hand edge of the row two above.
  assign wrap       = col == '0;
  assign centre_row = wrap ? row - RowW'(2) : row - RowW'(1);

  always_comb begin
    tok.src.luma        = flushing ? 8'd0 : pix.src_luma;
    tok.src.alpha       = flushing ? 8'd0 : pix.src_alpha;
    tok.prior.luma      = pix.prior_luma;
    tok.prior.alpha     = pix.prior_alpha;
    tok.col             = col;
    tok.ctl.emit        = wrap ? (row >= RowW'(2)) : (row >= RowW'(1));
    tok.ctl.frame_end   = wrap && (row == RowW'(eh) + RowW'(1));
    tok.ctl.left_mask   = wrap ? (ew == WidthW'(1)) : (col == ColW'(1));
    tok.ctl.right_mask  = wrap;
    tok.ctl.top_mask    = centre_row == '0;
    tok.ctl.bot_mask    = centre_row == RowW'(eh) - RowW'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ew       <= lagf_pkg::WidthReset;
      eh       <= lagf_pkg::HeightReset;
      col      <= '0;
      row      <= '0;
      flushing <= 1'b0;
    end else if (cfg_wen) begin
      // A write to either register abandons the frame in progress.
      if (cfg_index == lagf_pkg::REG_FRAME_WIDTH) begin
        ew       <= w_clamp;
        col      <= '0;
        row      <= '0;
        flushing <= 1'b0;
      end else if (cfg_index == lagf_pkg::REG_FRAME_HEIGHT) begin
        eh       <= h_clamp;
        col      <= '0;
        row      <= '0;
        flushing <= 1'b0;
      end
    end else if (push) begin
      if (final_tok) begin
        flushing <= 1'b0;
        col      <= '0;
        row      <= '0;
      end else if (col_last) begin
        col <= '0;
        row <= row + RowW'(1);
        if (!flushing && row_last) begin
          flushing <= 1'b1;
        end
      end else begin
        col <= col + ColW'(1);
      end
    end
  end

endmodule

// ===== rtl/lagf_queue.sv =====
// Short token queue between the front and back ends of the grow filter.
// Holds lagf_pkg::token_t entries; uses lagf_pkg.
module lagf_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  lagf_pkg::token_t push_tok,
  output logic             full,
  input  logic             pop,
  output logic             empty,
  output lagf_pkg::token_t head
);

  localparam int AddrW = lagf_pkg::QueueAddrW;

  lagf_pkg::token_t slots [lagf_pkg::QueueDepth];
  logic [AddrW-1:0] wr_ptr;
  logic [AddrW-1:0] rd_ptr;
  logic [AddrW:0]   count;
  logic             push_ok;
  logic             pop_ok;

  assign full    = count == (AddrW + 1)'(lagf_pkg::QueueDepth);
  assign empty   = count == '0;
  assign head    = slots[rd_ptr];
  assign push_ok = push && !full;
  assign pop_ok  = pop && !empty;

  always_ff @(posedge clk) begin
    if (push_ok) begin
      slots[wr_ptr] <= push_tok;
    end
  end

  // The depth is a power of two, so the pointers wrap on their own.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push_ok) begin
        wr_ptr <= wr_ptr + AddrW'(1);
      end
      if (pop_ok) begin
        rd_ptr <= rd_ptr + AddrW'(1);
      end
      unique case ({push_ok, pop_ok})
        2'b10:   count <= count + (AddrW + 1)'(1);
        2'b01:   count <= count - (AddrW + 1)'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== rtl/lagf_back.sv =====
// Back end: line store, two-column sliding window and the saturating 3x3 sum.
// Consumes tokens from lagf_queue and drives the result register; uses lagf_pkg.
module lagf_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_empty,
  input  lagf_pkg::token_t q_head,
  output logic             pop,
  output logic             res_valid,
  input  logic             res_ready,
  output lagf_pkg::res_t   res
);

  localparam int SumW  = lagf_pkg::SumW;
  localparam int ColSW = 10;

  logic en;

  lagf_pkg::line_t   mem [lagf_pkg::MaxWidth];
  lagf_pkg::line_t   rd_data;
  lagf_pkg::line_t   byp_data;
  logic              byp;
  logic              s1_valid;
  lagf_pkg::token_t  s1_tok;
  lagf_pkg::line_t   line;
  lagf_pkg::line_t   wr_line;
  lagf_pkg::column_t new_col;
  lagf_pkg::column_t win_b;
  lagf_pkg::column_t win_c;

  logic              s2_valid;
  lagf_pkg::column_t s2_cols [3];
  lagf_pkg::tok_ctl_t s2_ctl;

  lagf_pkg::pel_t    g_top [3];
  lagf_pkg::pel_t    g_mid [3];
  lagf_pkg::pel_t    g_bot [3];
  logic [ColSW-1:0]  col_luma [3];
  logic [ColSW-1:0]  col_alpha [3];
  logic [SumW-1:0]   luma_sum;
  logic [SumW-1:0]   alpha_sum;
  logic [2:0]        col_keep;

  function automatic lagf_pkg::pel_t gate(lagf_pkg::pel_t p, logic keep);
    return (keep && p.alpha != 8'd0) ? p : '0;
  endfunction

  // The whole pipeline holds while a result waits to be taken.
  assign en  = !res_valid || res_ready;
  assign pop = en && !q_empty;

  always_ff @(posedge clk) begin
    if (pop) begin
      rd_data <= mem[q_head.col];
    end
    if (en && s1_valid) begin
      mem[s1_tok.col] <= wr_line;
    end
  end

  // With a one-pixel row the same entry is read while it is being written.
  always_ff @(posedge clk) begin
    if (pop) begin
      s1_tok   <= q_head;
      byp      <= s1_valid && (s1_tok.col == q_head.col);
      byp_data <= wr_line;
    end
  end

  always_comb begin
    line          = byp ? byp_data : rd_data;
    wr_line.up1   = s1_tok.src;
    wr_line.up2   = line.up1;
    wr_line.prior1 = s1_tok.prior;
    new_col.top   = line.up2;
    new_col.mid   = line.up1;
    new_col.bot   = s1_tok.src;
    new_col.prior = line.prior1;
  end

  always_ff @(posedge clk) begin
    if (en && s1_valid) begin
      win_b      <= win_c;
      win_c      <= new_col;
      s2_cols[0] <= win_b;
      s2_cols[1] <= win_c;
      s2_cols[2] <= new_col;
      s2_ctl     <= s1_tok.ctl;
    end
  end

  always_comb begin
    col_keep = {!s2_ctl.right_mask, 1'b1, !s2_ctl.left_mask};
    for (int k = 0; k < 3; k++) begin
      g_top[k] = gate(s2_cols[k].top, col_keep[k] && !s2_ctl.top_mask);
      g_mid[k] = gate(s2_cols[k].mid, col_keep[k]);
      g_bot[k] = gate(s2_cols[k].bot, col_keep[k] && !s2_ctl.bot_mask);
      col_luma[k]  = ColSW'(g_top[k].luma) + ColSW'(g_mid[k].luma)
                   + ColSW'(g_bot[k].luma);
      col_alpha[k] = ColSW'(g_top[k].alpha) + ColSW'(g_mid[k].alpha)
                   + ColSW'(g_bot[k].alpha);
    end
    luma_sum  = SumW'(s2_cols[1].prior.luma) + SumW'(col_luma[0])
              + SumW'(col_luma[1]) + SumW'(col_luma[2]);
    alpha_sum = SumW'(s2_cols[1].prior.alpha) + SumW'(col_alpha[0])
              + SumW'(col_alpha[1]) + SumW'(col_alpha[2]);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res.out_luma  <= (luma_sum > SumW'(lagf_pkg::ChanMax)) ? lagf_pkg::ChanMax
                                                             : luma_sum[7:0];
      res.out_alpha <= (alpha_sum > SumW'(lagf_pkg::ChanMax)) ? lagf_pkg::ChanMax
                                                              : alpha_sum[7:0];
      res.frame_end <= s2_ctl.frame_end;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      res_valid <= 1'b0;
    end else if (en) begin
      s1_valid  <= pop;
      s2_valid  <= s1_valid;
      res_valid <= s2_valid && s2_ctl.emit;
    end
  end

endmodule

// ===== rtl/lum_alpha_grow_filter_3x3.sv =====
// Top level of the luminance/alpha 3x3 grow filter.
// Instantiates lagf_front, lagf_queue and lagf_back; uses lagf_pkg.
//
// Streams one raster-order source pixel, with the destination pixel already at
// that place, per item and returns each destination pixel grown by the sum of
// every lit (non-zero alpha) source pixel in its in-image 3x3 neighbourhood,
// both channels saturating at 255. The block takes one item per clock cycle
// while its token queue has room; results lag items by one row and one pixel.
// After a frame's last item the front end issues frame_width + 1 flush steps,
// one per cycle while the queue has room, during which no item is taken; the
// final result carries frame_end. The window is fed by a single line store of
// one entry per column, read and written at most once per cycle. Writing either
// register abandons the frame in progress and restarts at its first pixel.
module lum_alpha_grow_filter_3x3 (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            pix_valid,
  output logic                            pix_ready,
  input  lagf_pkg::pix_t                  pix,
  output logic                            res_valid,
  input  logic                            res_ready,
  output lagf_pkg::res_t                  res,
  input  logic                            cfg_wen,
  input  logic [lagf_pkg::CfgIndexW-1:0]  cfg_index,
  input  logic [lagf_pkg::CfgDataW-1:0]   cfg_data
);

  logic             q_push;
  logic             q_full;
  logic             q_pop;
  logic             q_empty;
  lagf_pkg::token_t push_tok;
  lagf_pkg::token_t q_head;

  lagf_front u_front (
    .clk       (clk),
    .rst       (rst),
    .pix_valid (pix_valid),
    .pix_ready (pix_ready),
    .pix       (pix),
    .cfg_wen   (cfg_wen),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_full    (q_full),
    .push      (q_push),
    .tok       (push_tok)
  );

  lagf_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_tok (push_tok),
    .full     (q_full),
    .pop      (q_pop),
    .empty    (q_empty),
    .head     (q_head)
  );

  lagf_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .q_head    (q_head),
    .pop       (q_pop),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

endmodule
